// ===== hw/rtl/qau_pkg.sv =====
package qau_pkg;

  localparam int unsigned LANES = 4;
  localparam int unsigned SQRT_BITS = 16;

  typedef enum logic [1:0] {
    ACT_PRODUCT   = 2'd0,
    ACT_ROTATE    = 2'd1,
    ACT_NORMALIZE = 2'd2,
    ACT_NONE      = 2'd3
  } action_t;

  // Control and finished product/rotate values that ride along the
  // inverse square root stages.
  typedef struct packed {
    action_t                     action;
    logic [LANES-1:0][15:0]      res;
    logic                        sat;
    logic                        zl;
    logic [LANES-1:0]            neg;
  } side_t;

endpackage

// ===== hw/rtl/qau_hprod.sv =====
module qau_hprod #(
  parameter int PW = 16,
  parameter int QW = 16
) (
  input  logic                     clk,
  input  logic                     en_mul,
  input  logic                     en_sum,
  input  logic signed [PW-1:0]     p [4],
  input  logic signed [QW-1:0]     q [4],
  output logic signed [PW+QW+1:0]  r [4]
);

  localparam int MW = PW + QW;
  localparam int SW = PW + QW + 2;

  logic signed [MW-1:0] prod_r [4][4];
  logic signed [SW-1:0] sum_r [4];
  logic signed [SW-1:0] e [4][4];

  // stage one: all sixteen cross products
  always_ff @(posedge clk) begin
    if (en_mul) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          prod_r[i][j] <= MW'(p[i] * q[j]);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        e[i][j] = SW'(prod_r[i][j]);
      end
    end
  end

  // stage two: Hamilton sums
  always_ff @(posedge clk) begin
    if (en_sum) begin
      sum_r[0] <= e[0][0] - e[1][1] - e[2][2] - e[3][3];
      sum_r[1] <= e[0][1] + e[1][0] + e[2][3] - e[3][2];
      sum_r[2] <= e[0][2] - e[1][3] + e[2][0] + e[3][1];
      sum_r[3] <= e[0][3] + e[1][2] - e[2][1] + e[3][0];
    end
  end

  assign r = sum_r;

endmodule

// ===== hw/rtl/qau_isqrt_step.sv =====
module qau_isqrt_step #(
  parameter int NW  = 68,
  parameter int BIT = 15
) (
  input  logic               clk,
  input  logic               en,
  input  qau_pkg::side_t     side_i,
  input  logic [32:0]        n_i,
  input  logic [NW-1:0]      lim_i [4],
  input  logic [NW-1:0]      p_i [4],
  input  logic [NW-1:0]      q_i [4],
  input  logic [15:0]        m_i [4],
  output qau_pkg::side_t     side_o,
  output logic [32:0]        n_o,
  output logic [NW-1:0]      lim_o [4],
  output logic [NW-1:0]      p_o [4],
  output logic [NW-1:0]      q_o [4],
  output logic [15:0]        m_o [4]
);

  qau_pkg::side_t side_r;
  logic [32:0]    n_r;
  logic [NW-1:0]  lim_r [4];
  logic [NW-1:0]  p_r [4];
  logic [NW-1:0]  q_r [4];
  logic [15:0]    m_r [4];

  logic [NW-1:0]  nn;
  logic [NW-1:0]  trial [4];
  logic [NW-1:0]  p_nxt [4];
  logic [NW-1:0]  q_nxt [4];
  logic [15:0]    m_nxt [4];

  // P = (2m)^2 n and Q = 2m n; trial is (2m + 2^(BIT+1) - 1)^2 n
  always_comb begin
    nn = NW'(n_i);
    for (int i = 0; i < 4; i++) begin
      trial[i] = p_i[i] + (q_i[i] << (BIT + 2)) - (q_i[i] << 1)
               + (nn << (2 * BIT + 2)) - (nn << (BIT + 2)) + nn;
      if (trial[i] <= lim_i[i]) begin
        p_nxt[i] = p_i[i] + (q_i[i] << (BIT + 2)) + (nn << (2 * BIT + 2));
        q_nxt[i] = q_i[i] + (nn << (BIT + 1));
        m_nxt[i] = m_i[i] | (16'(1) << BIT);
      end else begin
        p_nxt[i] = p_i[i];
        q_nxt[i] = q_i[i];
        m_nxt[i] = m_i[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_i;
      n_r    <= n_i;
      lim_r  <= lim_i;
      p_r    <= p_nxt;
      q_r    <= q_nxt;
      m_r    <= m_nxt;
    end
  end

  assign side_o = side_r;
  assign n_o    = n_r;
  assign lim_o  = lim_r;
  assign p_o    = p_r;
  assign q_o    = q_r;
  assign m_o    = m_r;

endmodule

// ===== hw/rtl/quaternion_arithmetic_unit.sv =====
// Quaternion arithmetic unit, signed fixed point with FRAC_BITS fraction bits
// (Q2.14 by default). Each beat on the input carries an action and two
// quaternions a and b and yields exactly one result beat: action 0 gives the
// Hamilton product a*b, action 1 rotates the vector (b_x, b_y, b_z) as
// a*v*conj(a) with r_w forced to zero, action 2 scales a by the inverse of
// its length (zero_length set, result zero, when a is all zero), and action
// 3 gives an all-zero result. Results are rounded once and clipped to 16
// bits, with saturated flagging any clipped component. The unit is a
// 22-stage pipeline: two stages per Hamilton product (cross products, then
// sums), a rounding stage, sixteen stages of a bit-per-stage inverse square
// root search (one result bit each), and the output register. One beat is
// accepted per cycle while in_ready is high.
// Each stage holds its data only while the stage after it is full and
// stalled, so bubbles squeeze out under backpressure.
module quaternion_arithmetic_unit #(
  parameter int FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic signed [15:0] in_a_w,
  input  logic signed [15:0] in_a_x,
  input  logic signed [15:0] in_a_y,
  input  logic signed [15:0] in_a_z,
  input  logic signed [15:0] in_b_w,
  input  logic signed [15:0] in_b_x,
  input  logic signed [15:0] in_b_y,
  input  logic signed [15:0] in_b_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_r_w,
  output logic signed [15:0] out_r_x,
  output logic signed [15:0] out_r_y,
  output logic signed [15:0] out_r_z,
  output logic               out_saturated,
  output logic               out_zero_length
);

  localparam int NS = 22;        // pipeline stages
  localparam int SQ0 = 5;        // stage feeding the first root step
  localparam int RW = (2 * FRAC_BITS + 2 > 54) ? 2 * FRAC_BITS + 2 : 54;
  localparam int NW = (2 * FRAC_BITS + 34 > 68) ? 2 * FRAC_BITS + 34 : 68;
  localparam int NB = qau_pkg::SQRT_BITS;

  localparam logic signed [RW-1:0] MAXV = RW'(32767);
  localparam logic signed [RW-1:0] MINV = RW'(-32768);

  // ---------------------------------------------------------------------
  // Flow control: a stage loads when it is empty or its successor loads.
  // ---------------------------------------------------------------------
  logic [NS:1] vld_r;
  logic [NS:1] en;

  always_comb begin
    en[NS] = !vld_r[NS] || out_ready;
    for (int j = NS - 1; j >= 1; j--) begin
      en[j] = !vld_r[j] || en[j+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[1]) begin
        vld_r[1] <= in_valid;
      end
      for (int j = 2; j <= NS; j++) begin
        if (en[j]) begin
          vld_r[j] <= vld_r[j-1];
        end
      end
    end
  end

  assign in_ready  = en[1];
  assign out_valid = vld_r[NS];

  // ---------------------------------------------------------------------
  // Stages 1-2: a * b (rotate uses b with its scalar part zeroed)
  // ---------------------------------------------------------------------
  logic signed [15:0] a_in [4];
  logic signed [15:0] b_in [4];
  logic signed [33:0] t2 [4];

  always_comb begin
    a_in[0] = in_a_w;
    a_in[1] = in_a_x;
    a_in[2] = in_a_y;
    a_in[3] = in_a_z;
    b_in[0] = (qau_pkg::action_t'(in_action) == qau_pkg::ACT_ROTATE) ? 16'sd0 : in_b_w;
    b_in[1] = in_b_x;
    b_in[2] = in_b_y;
    b_in[3] = in_b_z;
  end

  qau_hprod #(.PW(16), .QW(16)) u_hprod_ab (
    .clk    (clk),
    .en_mul (en[1]),
    .en_sum (en[2]),
    .p      (a_in),
    .q      (b_in),
    .r      (t2)
  );

  qau_pkg::action_t   act1_r, act2_r, act3_r, act4_r;
  logic signed [15:0] a1_r [4];
  logic signed [15:0] a2_r [4];
  logic signed [15:0] a3_r [4];
  logic signed [15:0] a4_r [4];
  logic [31:0]        sq1_r [4];
  logic [31:0]        sq2_r [4];
  logic [31:0]        sq3_r [4];
  logic [31:0]        sq4_r [4];
  logic [32:0]        n2_r, n3_r, n4_r;
  logic signed [33:0] t3_r [4];
  logic signed [33:0] t4_r [4];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      act1_r <= qau_pkg::action_t'(in_action);
      for (int i = 0; i < 4; i++) begin
        a1_r[i]  <= a_in[i];
        sq1_r[i] <= 32'(a_in[i] * a_in[i]);
      end
    end
    if (en[2]) begin
      act2_r <= act1_r;
      a2_r   <= a1_r;
      sq2_r  <= sq1_r;
      n2_r   <= 33'(sq1_r[0]) + 33'(sq1_r[1]) + 33'(sq1_r[2]) + 33'(sq1_r[3]);
    end
    if (en[3]) begin
      act3_r <= act2_r;
      a3_r   <= a2_r;
      sq3_r  <= sq2_r;
      n3_r   <= n2_r;
      t3_r   <= t2;
    end
    if (en[4]) begin
      act4_r <= act3_r;
      a4_r   <= a3_r;
      sq4_r  <= sq3_r;
      n4_r   <= n3_r;
      t4_r   <= t3_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stages 3-4: (a*v) * conj(a)
  // ---------------------------------------------------------------------
  logic signed [16:0] conj_a [4];
  logic signed [52:0] r4 [4];

  always_comb begin
    conj_a[0] = 17'(a2_r[0]);
    for (int i = 1; i < 4; i++) begin
      conj_a[i] = -17'(a2_r[i]);
    end
  end

  qau_hprod #(.PW(34), .QW(17)) u_hprod_rot (
    .clk    (clk),
    .en_mul (en[3]),
    .en_sum (en[4]),
    .p      (t2),
    .q      (conj_a),
    .r      (r4)
  );

  // ---------------------------------------------------------------------
  // Stage 5: round and clip product/rotate, prepare the root search
  // ---------------------------------------------------------------------
  qau_pkg::side_t     side5_nxt;
  logic signed [RW-1:0] wide [4];
  logic [NW-1:0]      lim5_nxt [4];

  always_comb begin
    side5_nxt        = '0;
    side5_nxt.action = act4_r;
    side5_nxt.zl     = (n4_r == '0);
    for (int i = 0; i < 4; i++) begin
      side5_nxt.neg[i] = a4_r[i][15];
      lim5_nxt[i]      = NW'(sq4_r[i]) << (2 * FRAC_BITS + 2);
      if (act4_r == qau_pkg::ACT_ROTATE) begin
        wide[i] = (RW'(r4[i]) + (RW'(1) <<< (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS);
      end else begin
        wide[i] = (RW'(t4_r[i]) + (RW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      end
      // rotate drops the scalar part entirely
      if (act4_r == qau_pkg::ACT_ROTATE && i == 0) begin
        side5_nxt.res[i] = '0;
      end else if (wide[i] > MAXV) begin
        side5_nxt.res[i] = 16'h7fff;
        side5_nxt.sat    = 1'b1;
      end else if (wide[i] < MINV) begin
        side5_nxt.res[i] = 16'h8000;
        side5_nxt.sat    = 1'b1;
      end else begin
        side5_nxt.res[i] = wide[i][15:0];
      end
    end
  end

  qau_pkg::side_t side_s [NB+1];
  logic [32:0]    n_s [NB+1];
  logic [NW-1:0]  lim_s [NB+1][4];
  logic [NW-1:0]  p_s [NB+1][4];
  logic [NW-1:0]  q_s [NB+1][4];
  logic [15:0]    m_s [NB+1][4];

  qau_pkg::side_t side5_r;
  logic [32:0]    n5_r;
  logic [NW-1:0]  lim5_r [4];

  always_ff @(posedge clk) begin
    if (en[SQ0]) begin
      side5_r <= side5_nxt;
      n5_r    <= n4_r;
      lim5_r  <= lim5_nxt;
    end
  end

  always_comb begin
    side_s[0] = side5_r;
    n_s[0]    = n5_r;
    for (int i = 0; i < 4; i++) begin
      lim_s[0][i] = lim5_r[i];
      p_s[0][i]   = '0;
      q_s[0][i]   = '0;
      m_s[0][i]   = '0;
    end
  end

  // ---------------------------------------------------------------------
  // Stages 6-21: one result bit per stage, most significant first
  // ---------------------------------------------------------------------
  for (genvar g = 0; g < NB; g++) begin : g_root
    qau_isqrt_step #(.NW(NW), .BIT(NB - 1 - g)) u_step (
      .clk    (clk),
      .en     (en[SQ0 + 1 + g]),
      .side_i (side_s[g]),
      .n_i    (n_s[g]),
      .lim_i  (lim_s[g]),
      .p_i    (p_s[g]),
      .q_i    (q_s[g]),
      .m_i    (m_s[g]),
      .side_o (side_s[g+1]),
      .n_o    (n_s[g+1]),
      .lim_o  (lim_s[g+1]),
      .p_o    (p_s[g+1]),
      .q_o    (q_s[g+1]),
      .m_o    (m_s[g+1])
    );
  end

  // ---------------------------------------------------------------------
  // Stage 22: select the result and hold it for the consumer
  // ---------------------------------------------------------------------
  qau_pkg::side_t     fin;
  logic [15:0]        mag [4];
  logic [15:0]        res_nxt [4];
  logic               sat_nxt;
  logic               zl_nxt;
  logic [15:0]        res_r [4];
  logic               sat_r;
  logic               zl_r;

  always_comb begin
    fin     = side_s[NB];
    sat_nxt = 1'b0;
    zl_nxt  = 1'b0;
    for (int i = 0; i < 4; i++) begin
      res_nxt[i] = '0;
      // the search magnitude is capped at 32768
      mag[i] = (m_s[NB][i] > 16'h8000) ? 16'h8000 : m_s[NB][i];
    end
    case (fin.action)
      qau_pkg::ACT_PRODUCT, qau_pkg::ACT_ROTATE: begin
        sat_nxt = fin.sat;
        for (int i = 0; i < 4; i++) begin
          res_nxt[i] = fin.res[i];
        end
      end
      qau_pkg::ACT_NORMALIZE: begin
        if (fin.zl) begin
          zl_nxt = 1'b1;
        end else begin
          for (int i = 0; i < 4; i++) begin
            if (fin.neg[i]) begin
              res_nxt[i] = -mag[i];
            end else if (mag[i][15]) begin
              res_nxt[i] = 16'h7fff;
              sat_nxt    = 1'b1;
            end else begin
              res_nxt[i] = mag[i];
            end
          end
        end
      end
      default: begin
        sat_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[NS]) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
      zl_r  <= zl_nxt;
    end
  end

  assign out_r_w         = res_r[0];
  assign out_r_x         = res_r[1];
  assign out_r_y         = res_r[2];
  assign out_r_z         = res_r[3];
  assign out_saturated   = sat_r;
  assign out_zero_length = zl_r;

endmodule

// ===== hw/rtl/qau_checker.sv =====
module qau_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_r_w,
  input logic signed [15:0] out_r_x,
  input logic signed [15:0] out_r_y,
  input logic signed [15:0] out_r_z,
  input logic               out_saturated,
  input logic               out_zero_length
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_r_w) && $stable(out_r_x) &&
      $stable(out_r_y) && $stable(out_r_z) && $stable(out_saturated) &&
      $stable(out_zero_length))
    else $error("result payload changed under stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_zl_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_length |-> out_r_w == 16'sd0 && out_r_x == 16'sd0 &&
      out_r_y == 16'sd0 && out_r_z == 16'sd0 && !out_saturated)
    else $error("zero length result not cleared");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

endmodule

bind quaternion_arithmetic_unit qau_checker u_qau_checker (.*);
